/* rtl/core/tpmh_pkg.sv */
package tpmh_pkg;

  // Field widths fixed by the item formats
  localparam int MIS_W       = 10;
  localparam int GRP_W       = 2;
  localparam int BIN_W       = 7;
  localparam int CNT_FIELD_W = 16;
  localparam int PIU_W       = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int NUM_ALLOWED = 4;
  localparam int THR0_W      = MIS_W + 1;
  localparam int THR1_W      = MIS_W + 2;

  // A missing hit is reported as 100 mismatches (tenths)
  localparam logic [MIS_W-1:0] NO_HIT_TENTHS = 10'd1000;

  // Operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Group codes
  localparam logic [GRP_W-1:0] GRP_IN  = 2'd0;
  localparam logic [GRP_W-1:0] GRP_OUT = 2'd1;

  // Grades
  localparam logic [1:0] GRADE_MATCH = 2'd0;
  localparam logic [1:0] GRADE_NEAR  = 2'd1;
  localparam logic [1:0] GRADE_MISS  = 2'd2;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROBES_IN_USE = 3'd0,
    REG_ALLOW_0       = 3'd1,
    REG_ALLOW_1       = 3'd2,
    REG_ALLOW_2       = 3'd3,
    REG_ALLOW_3       = 3'd4,
    REG_GREY_ZONE     = 3'd5,
    REG_OUTSIDE_DIFF  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic             operation;
    logic [MIS_W-1:0] mismatch;
    logic [GRP_W-1:0] group;
    logic             last_probe;
    logic [BIN_W-1:0] read_bin;
  } in_item_t;

  typedef struct packed {
    logic [BIN_W-1:0]       bin;
    logic [CNT_FIELD_W-1:0] in_count;
    logic [CNT_FIELD_W-1:0] out_count;
  } out_item_t;

  typedef struct packed {
    logic [PIU_W-1:0]                  probes_in_use;
    logic [NUM_ALLOWED-1:0][MIS_W-1:0] allow_tenths;
    logic [MIS_W-1:0]                  grey_zone;
    logic [MIS_W-1:0]                  outside_diff;
  } cfg_t;

  // Register values after reset: four probes, all margins zero
  localparam cfg_t CFG_RESET = '{
    probes_in_use: 3'd4,
    allow_tenths:  '0,
    grey_zone:     '0,
    outside_diff:  '0
  };

  // Request handed from the index stage to the update stage
  typedef struct packed {
    logic             is_read;
    logic [GRP_W-1:0] group;
    logic             in_range;
    logic [BIN_W-1:0] bin;
  } hist_req_t;

  // 3 to the power n, elaboration and constant-index use
  function automatic int pow3(input int n);
    int r;
    r = 1;
    for (int i = 0; i < n; i++) begin
      r = r * 3;
    end
    return r;
  endfunction

  // Grade one mismatch against the thresholds of the selected probe
  function automatic logic [1:0] grade_of(input cfg_t cfg, input logic [1:0] sel,
                                          input logic [MIS_W-1:0] mis);
    logic [THR0_W-1:0] t0;
    logic [THR1_W-1:0] t1;
    t0 = {1'b0, cfg.allow_tenths[sel]} + {1'b0, cfg.grey_zone};
    t1 = {1'b0, t0} + {2'b0, cfg.outside_diff};
    if ({1'b0, mis} <= t0) begin
      return GRADE_MATCH;
    end else if ({2'b0, mis} <= t1) begin
      return GRADE_NEAR;
    end
    return GRADE_MISS;
  endfunction

endpackage

/* rtl/core/tpmh_cfg_regs.sv */
module tpmh_cfg_regs
  import tpmh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [MIS_W-1:0]     wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Register write decode; an index past the list is dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_PROBES_IN_USE: cfg_nxt.probes_in_use   = wr_data[PIU_W-1:0];
        REG_ALLOW_0:       cfg_nxt.allow_tenths[0] = wr_data;
        REG_ALLOW_1:       cfg_nxt.allow_tenths[1] = wr_data;
        REG_ALLOW_2:       cfg_nxt.allow_tenths[2] = wr_data;
        REG_ALLOW_3:       cfg_nxt.allow_tenths[3] = wr_data;
        REG_GREY_ZONE:     cfg_nxt.grey_zone       = wr_data;
        REG_OUTSIDE_DIFF:  cfg_nxt.outside_diff    = wr_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/tpmh_index.sv */
module tpmh_index
  import tpmh_pkg::*;
#(
  parameter int MAX_PROBES = 4,
  parameter int IDX_W      = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_load,
  input  in_item_t         in_item,
  input  logic             s1_go,
  output logic             s1_vld,
  output logic             s1_has_res,
  output hist_req_t        s1_req,
  output logic [IDX_W-1:0] s1_addr
);

  localparam int Depth = pow3(MAX_PROBES);
  localparam int POS_W = $clog2(MAX_PROBES + 1);

  logic             s1_vld_r, s1_vld_nxt;
  in_item_t         s1_item_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] part_r, part_nxt;

  logic [PIU_W-1:0] eff;
  logic             take;
  logic [1:0]       sel;
  logic [1:0]       cur_grade;
  logic [IDX_W-1:0] cur_w;
  logic [IDX_W-1:0] contrib;
  logic [IDX_W-1:0] part_take;
  logic [POS_W-1:0] pos_after;
  logic [IDX_W-1:0] fill;
  logic [IDX_W-1:0] idx_final;
  logic [1:0]       miss_grade;
  logic             is_read;

  // Effective probe count, limited to 1..MAX_PROBES
  always_comb begin
    if (cfg.probes_in_use == '0) begin
      eff = PIU_W'(1);
    end else if (int'(cfg.probes_in_use) > MAX_PROBES) begin
      eff = PIU_W'(MAX_PROBES);
    end else begin
      eff = cfg.probes_in_use;
    end
  end

  // Grade the current sample and add its digit
  always_comb begin
    take      = PIU_W'(pos_r) < eff;
    sel       = (int'(pos_r) > 3) ? 2'd3 : 2'(pos_r);
    cur_grade = grade_of(cfg, sel, s1_item_r.mismatch);
    cur_w     = '0;
    for (int p = 0; p < MAX_PROBES; p++) begin
      if (int'(pos_r) == p) cur_w = IDX_W'(pow3(p));
    end
    case (cur_grade)
      GRADE_NEAR: contrib = cur_w;
      GRADE_MISS: contrib = IDX_W'(cur_w << 1);
      default:    contrib = '0;
    endcase
    part_take = take ? (part_r + contrib) : part_r;
    pos_after = take ? (pos_r + POS_W'(1)) : pos_r;
  end

  // Probes not supplied before the last one count as missing hits
  always_comb begin
    fill       = '0;
    miss_grade = GRADE_MATCH;
    for (int p = 0; p < MAX_PROBES; p++) begin
      miss_grade = grade_of(cfg, (p > 3) ? 2'd3 : 2'(p), NO_HIT_TENTHS);
      if ((int'(pos_after) <= p) && (p < int'(eff))) begin
        case (miss_grade)
          GRADE_NEAR: fill = fill + IDX_W'(pow3(p));
          GRADE_MISS: fill = fill + IDX_W'(2 * pow3(p));
          default:    fill = fill;
        endcase
      end
    end
    idx_final = part_take + fill;
  end

  // Request toward the histogram
  always_comb begin
    is_read         = (s1_item_r.operation == OP_READ);
    s1_has_res      = is_read || s1_item_r.last_probe;
    s1_req.is_read  = is_read;
    s1_req.group    = s1_item_r.group;
    s1_req.in_range = is_read ? (int'(s1_item_r.read_bin) < Depth) : 1'b1;
    s1_req.bin      = is_read ? s1_item_r.read_bin : BIN_W'(idx_final);
    s1_addr         = is_read ? IDX_W'(s1_item_r.read_bin) : idx_final;
  end

  // Species walk state advances as each sample leaves the stage
  always_comb begin
    pos_nxt    = pos_r;
    part_nxt   = part_r;
    s1_vld_nxt = s1_vld_r;
    if (s1_go && !is_read) begin
      if (s1_item_r.last_probe) begin
        pos_nxt  = '0;
        part_nxt = '0;
      end else begin
        pos_nxt  = pos_after;
        part_nxt = part_take;
      end
    end
    if (in_load) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_go) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      pos_r    <= '0;
      part_r   <= '0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      pos_r    <= pos_nxt;
      part_r   <= part_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) s1_item_r <= in_item;
  end

  assign s1_vld = s1_vld_r;

endmodule

/* rtl/core/tpmh_hist_ram.sv */
module tpmh_hist_ram
  import tpmh_pkg::*;
#(
  parameter int MAX_PROBES = 4,
  parameter int COUNT_BITS = 16,
  parameter int IDX_W      = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_addr,
  output logic [COUNT_BITS-1:0] rd_in,
  output logic [COUNT_BITS-1:0] rd_out,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_addr,
  input  logic [COUNT_BITS-1:0] wr_in,
  input  logic [COUNT_BITS-1:0] wr_out,
  output logic                  clr_busy
);

  localparam int Depth  = pow3(MAX_PROBES);
  localparam int WORD_W = 2 * COUNT_BITS;

  // One word per bin: out-group count above in-group count
  logic [WORD_W-1:0] mem [Depth];
  logic [WORD_W-1:0] rd_q_r;

  logic              clr_busy_r, clr_busy_nxt;
  logic [IDX_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic              we;
  logic [IDX_W-1:0]  wa;
  logic [WORD_W-1:0] wd;

  // Clearing sweep after reset, one bin per cycle
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + IDX_W'(1);
      if (clr_addr_r == IDX_W'(Depth - 1)) clr_busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Write port shared by the sweep and the update stage
  always_comb begin
    we = clr_busy_r || wr_en;
    wa = clr_busy_r ? clr_addr_r : wr_addr;
    wd = clr_busy_r ? '0 : {wr_out, wr_in};
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_q_r <= mem[rd_addr];
  end

  assign rd_in    = rd_q_r[COUNT_BITS-1:0];
  assign rd_out   = rd_q_r[WORD_W-1:COUNT_BITS];
  assign clr_busy = clr_busy_r;

endmodule

/* rtl/core/tpmh_update.sv */
module tpmh_update
  import tpmh_pkg::*;
#(
  parameter int COUNT_BITS = 16,
  parameter int IDX_W      = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  s2_load,
  input  hist_req_t             s1_req,
  input  logic [IDX_W-1:0]      s1_addr,
  output logic                  s2_free,
  input  logic [COUNT_BITS-1:0] rd_in,
  input  logic [COUNT_BITS-1:0] rd_out,
  output logic                  wr_en,
  output logic [IDX_W-1:0]      wr_addr,
  output logic [COUNT_BITS-1:0] wr_in,
  output logic [COUNT_BITS-1:0] wr_out,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item
);

  logic                  s2_vld_r;
  hist_req_t             s2_req_r;
  logic [IDX_W-1:0]      s2_addr_r;

  logic                  fwd_vld_r;
  logic [IDX_W-1:0]      fwd_addr_r;
  logic [COUNT_BITS-1:0] fwd_in_r, fwd_out_r;

  logic                  out_vld_r;
  out_item_t             out_item_r, out_item_nxt;

  logic                  s3_load, s2_go, fwd_hit, upd;
  logic [COUNT_BITS-1:0] cur_in, cur_out, new_in, new_out;

  // Handshake between the update stage and the output register
  assign s3_load = !out_vld_r || out_ready;
  assign s2_go   = s2_vld_r && s3_load;
  assign s2_free = !s2_vld_r || s2_go;

  // Bypass the bin written on the same edge that this bin was read
  always_comb begin
    fwd_hit = fwd_vld_r && (fwd_addr_r == s2_addr_r);
    cur_in  = fwd_hit ? fwd_in_r  : rd_in;
    cur_out = fwd_hit ? fwd_out_r : rd_out;
  end

  // Saturating increment of the chosen group
  always_comb begin
    upd     = !s2_req_r.is_read;
    new_in  = cur_in;
    new_out = cur_out;
    if (upd && (s2_req_r.group == GRP_IN) && !(&cur_in)) begin
      new_in = cur_in + COUNT_BITS'(1);
    end
    if (upd && (s2_req_r.group == GRP_OUT) && !(&cur_out)) begin
      new_out = cur_out + COUNT_BITS'(1);
    end
    wr_en   = s2_go && upd;
    wr_addr = s2_addr_r;
    wr_in   = new_in;
    wr_out  = new_out;
  end

  // Result beat; a bin past the histogram reads as zero
  always_comb begin
    out_item_nxt.bin       = s2_req_r.bin;
    out_item_nxt.in_count  = s2_req_r.in_range ? CNT_FIELD_W'(new_in) : '0;
    out_item_nxt.out_count = s2_req_r.in_range ? CNT_FIELD_W'(new_out) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r  <= 1'b0;
      fwd_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s2_load) begin
        s2_vld_r <= 1'b1;
      end else if (s2_go) begin
        s2_vld_r <= 1'b0;
      end
      if (wr_en) fwd_vld_r <= 1'b1;
      if (s2_go) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_req_r  <= s1_req;
      s2_addr_r <= s1_addr;
    end
    if (wr_en) begin
      fwd_addr_r <= s2_addr_r;
      fwd_in_r   <= new_in;
      fwd_out_r  <= new_out;
    end
    if (s2_go) out_item_r <= out_item_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule

/* rtl/core/ternary_probe_match_histogram_unit.sv */
// Channel  | Direction | Handshake           | Payload
// in_      | input     | in_valid/in_ready   | in_item (operation, mismatch, group, ...)
// out_     | output    | out_valid/out_ready | out_item (bin, in_count, out_count)
// cfg_     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item per cycle unless an output stall or the clearing sweep holds in_ready low; a
// result passes through the index stage, the histogram read and the output register.
// The histogram memory has a single write port and a registered read port;
// back-to-back hits on one bin are bypassed from the last write.
// After reset a clearing sweep over all 3^MAX_PROBES bins (81 by default) holds
// in_ready low; configuration writes are taken throughout.
// An output stall backs up through the stages; empty stages still take beats.
module ternary_probe_match_histogram_unit
  import tpmh_pkg::*;
#(
  parameter int MAX_PROBES = 4,
  parameter int COUNT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MIS_W-1:0]     cfg_data
);

  localparam int Depth = pow3(MAX_PROBES);
  localparam int IDX_W = $clog2(Depth);

  cfg_t                  cfg;
  logic                  in_load, s1_go, s1_vld, s1_has_res, s2_free, clr_busy;
  hist_req_t             s1_req;
  logic [IDX_W-1:0]      s1_addr, wr_addr;
  logic [COUNT_BITS-1:0] rd_in, rd_out, wr_in, wr_out;
  logic                  wr_en;

  assign cfg_ready = 1'b1;

  // Stage advance: samples that close no species drop out here
  assign s1_go    = s1_vld && (!s1_has_res || s2_free);
  assign in_ready = (!s1_vld || s1_go) && !clr_busy;
  assign in_load  = in_valid && in_ready;

  tpmh_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tpmh_index #(
    .MAX_PROBES (MAX_PROBES),
    .IDX_W      (IDX_W)
  ) u_index (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_load    (in_load),
    .in_item    (in_item),
    .s1_go      (s1_go),
    .s1_vld     (s1_vld),
    .s1_has_res (s1_has_res),
    .s1_req     (s1_req),
    .s1_addr    (s1_addr)
  );

  tpmh_hist_ram #(
    .MAX_PROBES (MAX_PROBES),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W)
  ) u_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (s1_go && s1_has_res),
    .rd_addr  (s1_addr),
    .rd_in    (rd_in),
    .rd_out   (rd_out),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_in    (wr_in),
    .wr_out   (wr_out),
    .clr_busy (clr_busy)
  );

  tpmh_update #(
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W)
  ) u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2_load   (s1_go && s1_has_res),
    .s1_req    (s1_req),
    .s1_addr   (s1_addr),
    .s2_free   (s2_free),
    .rd_in     (rd_in),
    .rd_out    (rd_out),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_in     (wr_in),
    .wr_out    (wr_out),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

/* rtl/core/tpmh_checker.sv */
module tpmh_checker
  import tpmh_pkg::*;
#(
  parameter int MAX_PROBES = 4
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  localparam int Depth = pow3(MAX_PROBES);

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result beat changed while stalled");

  // The clearing sweep blocks input right after reset
  a_clear_blocks: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken during histogram clear");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // Nonzero counts only ever belong to a bin inside the histogram
  a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_item.in_count != '0) || (out_item.out_count != '0))
      |-> (int'(out_item.bin) < Depth))
    else $error("counts reported for a bin outside the histogram");

endmodule

bind ternary_probe_match_histogram_unit tpmh_checker #(
  .MAX_PROBES (MAX_PROBES)
) u_tpmh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

/* verif/testbench.sv */
import tpmh_pkg::*;

// Histogram image kept beside the block: grades each probe sample, builds the
// base-3 bin index and holds the bin reports still owed by the block.
class probe_histogram;
  localparam int HIST_BINS  = 81;
  localparam int NUM_REGS   = 7;
  localparam int MAX_PROBES = 4;
  localparam logic [CNT_FIELD_W-1:0] COUNT_CEIL = '1;

  logic [CNT_FIELD_W-1:0] in_hist [HIST_BINS];
  logic [CNT_FIELD_W-1:0] out_hist [HIST_BINS];
  int unsigned probe_pos;
  int unsigned partial_index;
  int unsigned place_weight;
  int unsigned regs [NUM_REGS];
  out_item_t   pending_reports [$];
  int unsigned errors;

  function new();
    foreach (in_hist[i]) begin
      in_hist[i]  = '0;
      out_hist[i] = '0;
    end
    probe_pos     = 0;
    partial_index = 0;
    place_weight  = 1;
    foreach (regs[i]) regs[i] = 0;
    regs[REG_PROBES_IN_USE] = 4;
    errors = 0;
  endfunction

  function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MIS_W-1:0] data);
    if (idx < NUM_REGS) begin
      regs[idx] = (idx == REG_PROBES_IN_USE) ? data[PIU_W-1:0] : data;
    end
  endfunction

  // probes_in_use clamped to 1..MAX_PROBES
  function int unsigned eff_probes();
    int unsigned n;
    n = regs[REG_PROBES_IN_USE];
    if (n < 1) n = 1;
    if (n > MAX_PROBES) n = MAX_PROBES;
    return n;
  endfunction

  function int unsigned probe_grade(input int unsigned mis, input int unsigned pos);
    int unsigned sel, t0, t1;
    sel = (pos > 3) ? 3 : pos;
    t0  = regs[REG_ALLOW_0 + sel] + regs[REG_GREY_ZONE];
    t1  = t0 + regs[REG_OUTSIDE_DIFF];
    if (mis <= t0) return GRADE_MATCH;
    if (mis <= t1) return GRADE_NEAR;
    return GRADE_MISS;
  endfunction

  // samples past the probe count add nothing
  function void take_probe(input int unsigned mis);
    if (probe_pos < eff_probes()) begin
      partial_index += probe_grade(mis, probe_pos) * place_weight;
      place_weight  *= 3;
      probe_pos++;
    end
  endfunction

  // bins beyond the histogram report zero counts
  function out_item_t bin_report(input int unsigned bin);
    out_item_t r;
    r.bin = bin[BIN_W-1:0];
    if (bin < HIST_BINS) begin
      r.in_count  = in_hist[bin];
      r.out_count = out_hist[bin];
    end else begin
      r.in_count  = '0;
      r.out_count = '0;
    end
    return r;
  endfunction

  // Input beat accepted: update the image, queue the report it causes
  function void take_beat(input in_item_t it);
    int unsigned bin;
    if (it.operation == OP_READ) begin
      pending_reports.push_back(bin_report(it.read_bin));
      return;
    end
    take_probe(it.mismatch);
    if (!it.last_probe) return;
    // probes not supplied count as a missing hit
    while (probe_pos < eff_probes()) take_probe(NO_HIT_TENTHS);
    bin = partial_index;
    if (bin < HIST_BINS) begin
      if (it.group == GRP_IN) begin
        if (in_hist[bin] != COUNT_CEIL) in_hist[bin]++;
      end else if (it.group == GRP_OUT) begin
        if (out_hist[bin] != COUNT_CEIL) out_hist[bin]++;
      end
    end
    pending_reports.push_back(bin_report(bin));
    probe_pos     = 0;
    partial_index = 0;
    place_weight  = 1;
  endfunction

  // Result beat accepted: compare with the oldest owed report
  function void check_report(input out_item_t got);
    out_item_t want;
    if (pending_reports.size() == 0) begin
      errors++;
      $display("%0t: unexpected report: expected none, actual bin %0d in %0d out %0d",
               $time, got.bin, got.in_count, got.out_count);
      return;
    end
    want = pending_reports.pop_front();
    if (got.bin !== want.bin || got.in_count !== want.in_count ||
        got.out_count !== want.out_count) begin
      errors++;
      $display("%0t: report mismatch: expected bin %0d in %0d out %0d,",
               $time, want.bin, want.in_count, want.out_count,
               " actual bin %0d in %0d out %0d",
               got.bin, got.in_count, got.out_count);
    end
  endfunction
endclass

module testbench;
  localparam int MIS_MAX      = (1 << MIS_W) - 1;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 150;
  localparam int STALL_LIMIT  = 1000;
  localparam int BURST_RUN    = 16;
  localparam int SEG_ITEMS    = 95;
  localparam logic [GRP_W-1:0]     GRP_UNKNOWN = 2'd2;
  localparam logic [GRP_W-1:0]     GRP_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MIS_W-1:0]     cfg_data  = '0;

  probe_histogram hist = new();
  bit             steady = 1'b0;
  int unsigned    sent_items = 0;
  int unsigned    send_quiet = 0;
  int unsigned    quiet_cycles = 0;

  always #6 clk = ~clk;

  ternary_probe_match_histogram_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Beat monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) hist.take_beat(in_item);
      if (out_valid && out_ready) hist.check_report(out_item);
      if (cfg_valid && cfg_ready) hist.set_reg(cfg_index, cfg_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Result sink: random stalls, quiet stretches, two long hold-offs
  initial begin : result_sink
    int unsigned stall, quiet_left, taken;
    quiet_left = 0;
    taken      = 0;
    wait (rst_n);
    forever begin
      if (!steady && (taken == 60 || taken == 200)) stall = LONG_HOLD;
      else if (steady || quiet_left > 0) stall = 0;
      else stall = $urandom_range(0, 7);
      if (quiet_left > 0) quiet_left--;
      else if ($urandom_range(0, 31) == 0) quiet_left = $urandom_range(10, 40);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = (steady || send_quiet > 0) ? 0 : $urandom_range(0, 7);
    if (send_quiet > 0) send_quiet--;
    else if ($urandom_range(0, 31) == 0) send_quiet = $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_items++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MIS_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Write every register back to back; upper data bits of the probe count are noise
  task automatic apply_settings(input int unsigned piu, a0, a1, a2, a3, grey, outside);
    logic [MIS_W-1:0] d;
    d = $urandom_range(0, MIS_MAX);
    d[PIU_W-1:0] = piu[PIU_W-1:0];
    write_reg(REG_UNUSED, $urandom_range(0, MIS_MAX));
    write_reg(REG_PROBES_IN_USE, d);
    write_reg(REG_ALLOW_0, a0[MIS_W-1:0]);
    write_reg(REG_ALLOW_1, a1[MIS_W-1:0]);
    write_reg(REG_ALLOW_2, a2[MIS_W-1:0]);
    write_reg(REG_ALLOW_3, a3[MIS_W-1:0]);
    write_reg(REG_GREY_ZONE, grey[MIS_W-1:0]);
    write_reg(REG_OUTSIDE_DIFF, outside[MIS_W-1:0]);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold input until every owed report has come, then let the pipe drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (hist.pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t sample(input int unsigned mis, input logic [GRP_W-1:0] grp,
                                      input logic last);
    in_item_t it;
    it.operation  = OP_SAMPLE;
    it.mismatch   = mis[MIS_W-1:0];
    it.group      = grp;
    it.last_probe = last;
    it.read_bin   = $urandom_range(0, 127);
    return it;
  endfunction

  function automatic in_item_t read_req(input int unsigned bin);
    in_item_t it;
    it.operation  = OP_READ;
    it.mismatch   = $urandom_range(0, MIS_MAX);
    it.group      = $urandom_range(0, 3);
    it.last_probe = $urandom_range(0, 1);
    it.read_bin   = bin[BIN_W-1:0];
    return it;
  endfunction

  function automatic int unsigned pick_bin();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(81, 127) : $urandom_range(0, 80);
  endfunction

  function automatic logic [GRP_W-1:0] pick_group();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return GRP_IN;
    if (r < 8) return GRP_OUT;
    return (r == 8) ? GRP_UNKNOWN : GRP_UNUSED;
  endfunction

  // Mismatch values clustered on the grade boundaries of this probe
  function automatic int unsigned pick_mismatch(input int unsigned pos);
    int unsigned sel, t0, t1, v;
    sel = (pos > 3) ? 3 : pos;
    t0  = hist.regs[REG_ALLOW_0 + sel] + hist.regs[REG_GREY_ZONE];
    t1  = t0 + hist.regs[REG_OUTSIDE_DIFF];
    case ($urandom_range(0, 9))
      0: v = t0;
      1: v = t0 + 1;
      2: v = t1;
      3: v = t1 + 1;
      4: v = (t0 > 0) ? t0 - 1 : 0;
      5: v = NO_HIT_TENTHS;
      6: v = MIS_MAX;
      default: v = $urandom_range(0, MIS_MAX);
    endcase
    if (v > MIS_MAX) v = $urandom_range(0, MIS_MAX);
    return v;
  endfunction

  // One species: mostly full length, some cut short, some with extra samples
  task automatic send_species();
    int unsigned eff, n, shape;
    eff   = hist.eff_probes();
    shape = $urandom_range(0, 9);
    if (shape == 7) n = $urandom_range(1, eff);
    else if (shape >= 8) n = eff + $urandom_range(1, 3);
    else n = eff;
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 11) == 0) send_item(read_req(pick_bin()));
      send_item(sample(pick_mismatch(k), pick_group(), k == n - 1));
    end
  endtask

  task automatic run_segment(input int unsigned items);
    int unsigned stop;
    stop = sent_items + items;
    while (sent_items < stop) begin
      case ($urandom_range(0, 9))
        0: send_item(in_item_t'($urandom));
        1: send_item(read_req(pick_bin()));
        default: send_species();
      endcase
    end
    // close whatever species the noise left open
    send_item(sample(pick_mismatch(0), pick_group(), 1'b1));
    settle();
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: boundaries, missing hit, short and long species, odd groups, reads
    apply_settings(4, 0, 10, 200, MIS_MAX, 5, 20);
    send_item(read_req(0));
    send_item(read_req(80));
    send_item(read_req(127));
    send_item(sample(5, GRP_IN, 1'b0));
    send_item(sample(35, GRP_IN, 1'b0));
    send_item(sample(226, GRP_IN, 1'b0));
    send_item(sample(MIS_MAX, GRP_IN, 1'b1));
    send_item(sample(6, GRP_IN, 1'b0));
    send_item(sample(36, GRP_IN, 1'b0));
    send_item(sample(0, GRP_IN, 1'b0));
    send_item(sample(NO_HIT_TENTHS, GRP_OUT, 1'b1));
    send_item(sample(0, GRP_OUT, 1'b1));
    send_item(sample(0, GRP_IN, 1'b0));
    send_item(sample(30, GRP_IN, 1'b0));
    send_item(sample(210, GRP_IN, 1'b0));
    send_item(sample(500, GRP_IN, 1'b0));
    send_item(sample(700, GRP_IN, 1'b0));
    send_item(sample(MIS_MAX, GRP_UNKNOWN, 1'b1));
    send_item(sample(100, GRP_IN, 1'b0));
    send_item(sample(12, GRP_UNUSED, 1'b1));
    send_item(read_req(21));
    send_item(read_req(0));
    settle();

    // Random: extreme settings first, then random ones
    apply_settings(0, MIS_MAX, MIS_MAX, MIS_MAX, MIS_MAX, MIS_MAX, MIS_MAX);
    run_segment(SEG_ITEMS);
    apply_settings(7, 0, 0, 0, 0, 0, 0);
    run_segment(SEG_ITEMS);
    repeat (5) begin
      apply_settings(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4),
                     $urandom_range(0, 300), $urandom_range(0, 300),
                     ($urandom_range(0, 5) == 0) ? MIS_MAX : $urandom_range(0, 300),
                     $urandom_range(0, 1000), $urandom_range(0, 100), $urandom_range(0, 200));
      run_segment(SEG_ITEMS);
    end

    // Back-to-back hits on one in-group and one out-group bin
    apply_settings(1, 0, 0, 0, 0, 0, 0);
    steady = 1'b1;
    repeat (BURST_RUN) send_item(sample(0, GRP_IN, 1'b1));
    repeat (BURST_RUN) send_item(sample(NO_HIT_TENTHS, GRP_OUT, 1'b1));
    steady = 1'b0;
    send_item(read_req(0));
    send_item(read_req(2));
    settle();

    if (hist.errors == 0 && hist.pending_reports.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

/* ternary_probe_match_histogram_unit.f */
rtl/core/tpmh_pkg.sv
rtl/core/tpmh_cfg_regs.sv
rtl/core/tpmh_index.sv
rtl/core/tpmh_hist_ram.sv
rtl/core/tpmh_update.sv
rtl/core/ternary_probe_match_histogram_unit.sv
rtl/core/tpmh_checker.sv
verif/testbench.sv
